/* src/bwlp_pkg.sv */
// Shared constants, types and the command struct for the Butterworth low-pass biquad bank.
package bwlp_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int HAND_COUNT_DEF   = 2;
  localparam int AXIS_COUNT_DEF   = 3;

  localparam int CFG_W  = 16;
  localparam int DEN_W  = 33;
  localparam int COEF_W = 35;
  localparam int KC_W   = 25;

  localparam logic [CFG_W-1:0] CUTOFF_RESET = 16'd1024;
  // 1.414 in Q17.16, nearest.
  localparam logic [32:0] K1414 = 33'd92668;

  typedef struct packed {
    logic load_in;
    logic calc_const;
    logic calc_coef;
    logic m1;
    logic m2;
    logic m3;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

endpackage

/* src/bwlp_smp_if.sv */
// Sample request channel: hand selector and three position samples.
interface bwlp_smp_if #(parameter int SW = 32);
  logic          valid;
  logic          ready;
  logic          hand_side;
  logic [SW-1:0] pos_x;
  logic [SW-1:0] pos_y;
  logic [SW-1:0] pos_z;
  modport source(output valid, hand_side, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, hand_side, pos_x, pos_y, pos_z, output ready);
endinterface

/* src/bwlp_res_if.sv */
// Result request channel: echoed selector and three filtered values.
interface bwlp_res_if #(parameter int SW = 32);
  logic          valid;
  logic          ready;
  logic          side_out;
  logic [SW-1:0] filt_x;
  logic [SW-1:0] filt_y;
  logic [SW-1:0] filt_z;
  modport source(output valid, side_out, filt_x, filt_y, filt_z, input ready);
  modport sink(input valid, side_out, filt_x, filt_y, filt_z, output ready);
endinterface

/* src/bwlp_cfg_if.sv */
// Configuration write channel carrying the cutoff ratio.
interface bwlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* src/butterworth_lowpass_biquad_top.sv */
// Top level of the second-order Butterworth low-pass filter bank.
// This block holds one second-order Butterworth low-pass filter per hand and axis
// and steps the selected hand's filters once for every accepted sample request.
// The result becomes valid once the coefficients are computed and every axis has
// been filtered in turn. After the result is taken the block returns to idle,
// where it can take the next request.
// Each axis takes two multiply steps and a pass through the restoring divider,
// which produces one quotient bit per cycle for each axis.
// The block works on one request at a time: the sample channel is ready only
// while the block is idle, and the result is held until the consumer takes it.
// Filter history lives in a small RAM with one row per filter; a valid bit per row,
// cleared at reset, makes rows that were never written read as zero, so no
// clearing pass is needed after reset.
// The cutoff ratio register accepts a write in every cycle and should be written
// only while the block is idle.
module butterworth_lowpass_biquad_top #(
  parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF,
  parameter int HAND_COUNT   = bwlp_pkg::HAND_COUNT_DEF,
  parameter int AXIS_COUNT   = bwlp_pkg::AXIS_COUNT_DEF
) (
  input logic   clk,
  input logic   rst,
  bwlp_smp_if.sink   smp,
  bwlp_res_if.source res,
  bwlp_cfg_if.sink   cfg
);
  import bwlp_pkg::*;

  localparam int AX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  cmd_t            cmd;
  logic [AX_W-1:0] axis;

  // The cutoff register never stalls a write.
  assign cfg.ready = 1'b1;

  bwlp_ctrl #(.SW(SAMPLE_WIDTH), .AC(AXIS_COUNT)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (smp.valid),
    .in_ready (smp.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .cmd      (cmd),
    .axis     (axis)
  );

  // The datapath latches the request when the controller accepts it and keeps
  // the result registers stable until the next request arrives.
  bwlp_dp #(.SW(SAMPLE_WIDTH), .HC(HAND_COUNT), .AC(AXIS_COUNT)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .axis        (axis),
    .in_hand_side(smp.hand_side),
    .in_x        (smp.pos_x),
    .in_y        (smp.pos_y),
    .in_z        (smp.pos_z),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .res_side    (res.side_out),
    .res_x       (res.filt_x),
    .res_y       (res.filt_y),
    .res_z       (res.filt_z)
  );
endmodule

/* src/bwlp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bwlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/bwlp_ctrl.sv */
// Sequencer that steps the datapath through coefficients, axes and division.
module bwlp_ctrl #(
  parameter int SW = 32,
  parameter int AC = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bwlp_pkg::cmd_t                      cmd,
  output logic [(AC > 1 ? $clog2(AC) : 1)-1:0] axis
);
  import bwlp_pkg::*;

  localparam int AX_W = (AC > 1) ? $clog2(AC) : 1;
  localparam int CW   = $clog2(SW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONST = 4'd1;
  localparam logic [3:0] S_COEF  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_DV0   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]      state, state_next;
  logic [CW-1:0]   cnt;
  logic [AX_W-1:0] axis_r;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign axis      = axis_r;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CONST;
        end
      end
      S_CONST: begin
        cmd.calc_const = 1'b1;
        state_next     = S_COEF;
      end
      S_COEF: begin
        cmd.calc_coef = 1'b1;
        state_next    = S_RD;
      end
      S_RD: state_next = S_M1;
      S_M1: begin
        cmd.m1     = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.m2     = 1'b1;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.m3     = 1'b1;
        state_next = S_DV0;
      end
      S_DV0: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CW'(SW - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = (axis_r == AX_W'(AC - 1)) ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      axis_r <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        axis_r <= '0;
      end else if (cmd.finish) begin
        axis_r <= axis_r + AX_W'(1);
      end
      if (cmd.div_init) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CW'(1);
      end
    end
  end
endmodule

/* src/bwlp_dp.sv */
// Datapath: cutoff register, coefficients, history RAM, multiply-accumulate and divider.
module bwlp_dp #(
  parameter int SW = 32,
  parameter int HC = 2,
  parameter int AC = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bwlp_pkg::cmd_t                       cmd,
  input  logic [(AC > 1 ? $clog2(AC) : 1)-1:0] axis,
  input  logic                                 in_hand_side,
  input  logic [SW-1:0]                        in_x,
  input  logic [SW-1:0]                        in_y,
  input  logic [SW-1:0]                        in_z,
  input  logic                                 cfg_we,
  input  logic [bwlp_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 res_side,
  output logic [SW-1:0]                        res_x,
  output logic [SW-1:0]                        res_y,
  output logic [SW-1:0]                        res_z
);
  import bwlp_pkg::*;

  localparam int ROWS   = HC * AC;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ACC_W  = SW + 37;
  localparam int PROD_W = SW + COEF_W;
  localparam int HW     = 4 * SW;

  logic [CFG_W-1:0]         cutoff;
  logic                     side_r;
  logic [SW-1:0]            smp [3];
  logic [31:0]              c2;
  logic [KC_W-1:0]          kc;
  logic [DEN_W-1:0]         den;
  logic signed [COEF_W-1:0] a1, a2;
  logic signed [SW-1:0]     hx0, hy0, hy1;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                     neg, sat;
  logic [DEN_W-1:0]         rem;
  logic [SW-1:0]            qsh;
  logic [SW-1:0]            res [3];
  logic [ROWS-1:0]          vld;

  logic [ROW_W-1:0]         row;
  logic [HW-1:0]            ram_q, hist, wdata;
  logic signed [SW-1:0]     h_x0, h_x1, h_y0, h_y1, x_new;
  logic signed [SW+1:0]     xs;
  logic [32:0]              kc_prod;
  logic [ACC_W-1:0]         mag, m;
  logic [DEN_W:0]           cur;
  logic                     ge;
  logic [SW-1:0]            lim, qs, y;

  always_comb begin
    int hand_i;
    hand_i = (int'(side_r) >= HC) ? HC - 1 : int'(side_r);
    row    = ROW_W'(hand_i * AC + int'(axis));
  end

  bwlp_ram #(.WIDTH(HW), .DEPTH(ROWS)) u_hist (
    .clk  (clk),
    .we   (cmd.finish),
    .waddr(row),
    .wdata(wdata),
    .raddr(row),
    .rdata(ram_q)
  );

  // Rows never written read as zero history.
  assign hist  = vld[row] ? ram_q : '0;
  assign h_x0  = hist[HW-1:3*SW];
  assign h_x1  = hist[3*SW-1:2*SW];
  assign h_y0  = hist[2*SW-1:SW];
  assign h_y1  = hist[SW-1:0];
  assign x_new = smp[axis];
  assign xs    = {{2{x_new[SW-1]}}, x_new} + {h_x0[SW-1], h_x0, 1'b0}
               + {{2{h_x1[SW-1]}}, h_x1};

  assign kc_prod = 33'(cutoff) * K1414;

  assign mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign m   = mag + ACC_W'(den >> 1);

  assign cur = {rem, qsh[SW-1]};
  assign ge  = cur >= {1'b0, den};

  assign lim   = neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  assign qs    = (sat || qsh > lim) ? lim : qsh;
  assign y     = neg ? SW'(-qs) : qs;
  assign wdata = {x_new, hx0, y, hy0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
      vld    <= '0;
    end else begin
      if (cfg_we) begin
        cutoff <= cfg_data;
      end
      if (cmd.finish) begin
        vld[row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      side_r <= in_hand_side;
      smp[0] <= in_x;
      smp[1] <= in_y;
      smp[2] <= in_z;
      for (int i = 0; i < 3; i++) begin
        res[i] <= '0;
      end
    end
    if (cmd.calc_const) begin
      c2 <= 32'(cutoff) * 32'(cutoff);
      kc <= KC_W'((kc_prod + 33'd128) >> 8);
    end
    if (cmd.calc_coef) begin
      den <= DEN_W'(17'h10000) + DEN_W'(c2) + DEN_W'(kc);
      a1  <= $signed(35'd131072) - $signed({2'b00, c2, 1'b0});
      a2  <= $signed({3'b000, c2}) - $signed({10'b0, kc}) + $signed(35'd65536);
    end
    if (cmd.m1) begin
      hx0  <= h_x0;
      hy0  <= h_y0;
      hy1  <= h_y1;
      acc  <= $signed({{(ACC_W-SW-18){xs[SW+1]}}, xs, 16'b0});
      prod <= a1 * h_y0;
    end
    if (cmd.m2) begin
      acc  <= acc - {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      prod <= a2 * hy1;
    end
    if (cmd.m3) begin
      acc <= acc - {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (cmd.div_init) begin
      neg <= acc[ACC_W-1];
      sat <= m >= ACC_W'({den, {SW{1'b0}}});
      rem <= m[SW+DEN_W-1:SW];
      qsh <= m[SW-1:0];
    end
    if (cmd.div_step) begin
      rem <= ge ? DEN_W'(cur - {1'b0, den}) : cur[DEN_W-1:0];
      qsh <= {qsh[SW-2:0], ge};
    end
    if (cmd.finish) begin
      for (int i = 0; i < 3; i++) begin
        if (i == int'(axis)) begin
          res[i] <= y;
        end
      end
    end
  end

  assign res_side = side_r;
  assign res_x    = res[0];
  assign res_y    = res[1];
  assign res_z    = res[2];
endmodule

/* src/bwlp_chk.sv */
// Port-level checker for the filter bank and its bind to the top level.
module bwlp_chk #(
  parameter int SW = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [SW-1:0] out_filt_x
);

  // A request is never answered in the cycle right after it is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result valid right after request accepted");

  // Exactly one result per request: valid drops once the result is taken.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated after it was taken");

  // No new request is taken while one is in work.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // A stalled result stays valid and its x value holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_filt_x)))
    else $error("stalled result changed");

endmodule

bind butterworth_lowpass_biquad_top bwlp_chk #(.SW(SAMPLE_WIDTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (smp.valid),
  .in_ready  (smp.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_filt_x(res.filt_x)
);
